### sv/q2r_pkg.sv
// Package for the quaternion to rotation matrix block.
// Holds the entry count constant; no dependencies.
`default_nettype none
package q2r_pkg;
  localparam int unsigned NumEntries = 9;
endpackage
`default_nettype wire

### sv/q2r_div_stage.sv
// One restoring step of the nine fraction divisions.
// Depends on q2r_pkg.
`default_nettype none
module q2r_div_stage import q2r_pkg::*; #(
  parameter int unsigned NW = 34,
  parameter int unsigned QW = 16
) (
  input  wire logic [NW-1:0] n_i,
  input  wire logic [NW-1:0] r_i [NumEntries],
  input  wire logic [QW-1:0] q_i [NumEntries],
  output logic      [NW-1:0] r_o [NumEntries],
  output logic      [QW-1:0] q_o [NumEntries]
);
  always_comb begin
    for (int k = 0; k < NumEntries; k++) begin
      if (r_i[k] >= n_i - r_i[k]) begin
        r_o[k] = r_i[k] - (n_i - r_i[k]);
        q_o[k] = {q_i[k][QW-2:0], 1'b1};
      end else begin
        r_o[k] = r_i[k] + r_i[k];
        q_o[k] = {q_i[k][QW-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

### sv/quaternion_to_rotation_matrix_top.sv
// Top level: quaternion to normalized 3x3 rotation matrix, deep pipeline.
// Depends on q2r_pkg and q2r_div_stage.
`default_nettype none
// One item enters every cycle; the result leaves with done_o high for one
// cycle. The pipeline holds one products stage, one sums stage and one
// division step per fraction bit, each in its own register stage, plus the
// final rounding stage. busy is always low and the receiver cannot stall the
// pipeline, so results must be taken as they leave.
module quaternion_to_rotation_matrix_top import q2r_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [DATA_WIDTH-1:0] q_w_i,
  input  wire logic signed [DATA_WIDTH-1:0] q_x_i,
  input  wire logic signed [DATA_WIDTH-1:0] q_y_i,
  input  wire logic signed [DATA_WIDTH-1:0] q_z_i,
  output logic                              done_o,
  output logic signed [DATA_WIDTH-1:0]      m_col0_row0_o,
  output logic signed [DATA_WIDTH-1:0]      m_col0_row1_o,
  output logic signed [DATA_WIDTH-1:0]      m_col0_row2_o,
  output logic signed [DATA_WIDTH-1:0]      m_col1_row0_o,
  output logic signed [DATA_WIDTH-1:0]      m_col1_row1_o,
  output logic signed [DATA_WIDTH-1:0]      m_col1_row2_o,
  output logic signed [DATA_WIDTH-1:0]      m_col2_row0_o,
  output logic signed [DATA_WIDTH-1:0]      m_col2_row1_o,
  output logic signed [DATA_WIDTH-1:0]      m_col2_row2_o,
  output logic                              zero_norm_o
);
  localparam int unsigned FB = DATA_WIDTH - 2;
  localparam int unsigned PW = 2 * DATA_WIDTH;
  localparam int unsigned NW = PW + 2;
  localparam int unsigned QW = DATA_WIDTH;

  assign busy = 1'b0;

  logic                 v1_q;
  logic signed [PW-1:0] ww_q, xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= start;
  end
  always_ff @(posedge clk_i) begin
    ww_q <= q_w_i * q_w_i; xx_q <= q_x_i * q_x_i;
    yy_q <= q_y_i * q_y_i; zz_q <= q_z_i * q_z_i;
    xy_q <= q_x_i * q_y_i; xz_q <= q_x_i * q_z_i; yz_q <= q_y_i * q_z_i;
    wx_q <= q_w_i * q_x_i; wy_q <= q_w_i * q_y_i; wz_q <= q_w_i * q_z_i;
  end

  logic signed [NW-1:0] p_d [NumEntries];
  logic        [NW-1:0] n_d;
  always_comb begin
    logic signed [NW-1:0] a, b, c, d, e, f, g, h, i, j;
    a = NW'(ww_q); b = NW'(xx_q); c = NW'(yy_q); d = NW'(zz_q);
    e = NW'(xy_q); f = NW'(xz_q); g = NW'(yz_q);
    h = NW'(wx_q); i = NW'(wy_q); j = NW'(wz_q);
    n_d = NW'(a + b + c + d);
    p_d[0] = a + b - c - d;
    p_d[1] = (e + j) <<< 1;
    p_d[2] = (f - i) <<< 1;
    p_d[3] = (e - j) <<< 1;
    p_d[4] = a - b + c - d;
    p_d[5] = (g + h) <<< 1;
    p_d[6] = (f + i) <<< 1;
    p_d[7] = (g - h) <<< 1;
    p_d[8] = a - b - c + d;
  end

  logic [FB+1:0]    v_q;
  logic [NW-1:0]    n_q [FB+1];
  logic [FB:0]      neg_q [NumEntries];
  logic [NW-1:0]    r_q [FB+1][NumEntries];
  logic [QW-1:0]    qt_q [FB+1][NumEntries];
  logic [NW-1:0]    r_s [FB][NumEntries];
  logic [QW-1:0]    qt_s [FB][NumEntries];
  logic [QW-1:0]    m_d [NumEntries];
  logic [QW-1:0]    m_q [NumEntries];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else v_q <= {v_q[FB:0], v1_q};
  end

  always_ff @(posedge clk_i) begin
    n_q[0] <= n_d;
    for (int k = 0; k < NumEntries; k++) begin
      logic [NW-1:0] mag;
      mag = p_d[k][NW-1] ? NW'(-p_d[k]) : NW'(p_d[k]);
      neg_q[k] <= {neg_q[k][FB-1:0], p_d[k][NW-1]};
      r_q[0][k]  <= (mag == n_d) ? '0 : mag;
      qt_q[0][k] <= (mag == n_d) ? QW'(1) : '0;
    end
    for (int s = 0; s < FB; s++) begin
      n_q[s+1]  <= n_q[s];
      r_q[s+1]  <= r_s[s];
      qt_q[s+1] <= qt_s[s];
    end
    m_q <= m_d;
  end

  for (genvar s = 0; s < FB; s++) begin : g_div
    q2r_div_stage #(.NW(NW), .QW(QW)) u_stage (
      .n_i(n_q[s]), .r_i(r_q[s]), .q_i(qt_q[s]), .r_o(r_s[s]), .q_o(qt_s[s])
    );
  end

  always_comb begin
    for (int k = 0; k < NumEntries; k++) begin
      logic [QW-1:0] qr;
      qr = qt_q[FB][k] + QW'(r_q[FB][k] >= n_q[FB] - r_q[FB][k]);
      m_d[k] = neg_q[k][FB] ? QW'(-qr) : qr;
      if (n_q[FB] == '0) m_d[k] = (k % 4 == 0) ? QW'(1) << FB : '0;
    end
  end

  logic zn_q;
  always_ff @(posedge clk_i) zn_q <= (n_q[FB] == '0);

  assign done_o        = v_q[FB+1];
  assign zero_norm_o   = zn_q;
  assign m_col0_row0_o = m_q[0];
  assign m_col0_row1_o = m_q[1];
  assign m_col0_row2_o = m_q[2];
  assign m_col1_row0_o = m_q[3];
  assign m_col1_row1_o = m_q[4];
  assign m_col1_row2_o = m_q[5];
  assign m_col2_row0_o = m_q[6];
  assign m_col2_row1_o = m_q[7];
  assign m_col2_row2_o = m_q[8];
endmodule
`default_nettype wire

### sv/q2r_checker.sv
// Port checker for the quaternion to rotation matrix block, bound to the top.
// Depends on quaternion_to_rotation_matrix_top.
`default_nettype none
module q2r_checker #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  done_o,
  input wire logic [DATA_WIDTH-1:0] m_col0_row0_o,
  input wire logic [DATA_WIDTH-1:0] m_col0_row1_o,
  input wire logic                  zero_norm_o
);
  localparam logic [DATA_WIDTH-1:0] One = 1 << (DATA_WIDTH - 2);
  a_never_busy: assert property (@(posedge clk_i) !busy) else $error("busy high");
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##(DATA_WIDTH + 1) done_o) else $error("item lost");
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, DATA_WIDTH + 1)) else $error("item invented");
  a_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && zero_norm_o |-> m_col0_row0_o == One && m_col0_row1_o == '0)
    else $error("zero quaternion not identity");
endmodule

bind quaternion_to_rotation_matrix_top q2r_checker #(.DATA_WIDTH(DATA_WIDTH)) u_chk (
  .clk_i, .rst_ni, .start, .busy, .done_o, .m_col0_row0_o, .m_col0_row1_o, .zero_norm_o
);
`default_nettype wire
